@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the process table RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define PT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define PT_ASSERT(lbl, prop, msg)
`define PT_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

@@ hw/rtl/ptlp_pkg.sv @@
// Package for the process table: item types, codes and controller/datapath structs.
// No dependencies.
package ptlp_pkg;

  localparam int PID_W  = 23;
  localparam int UID_W  = 32;
  localparam int CMD_W  = 3;
  localparam int STAT_W = 3;
  localparam int SLOT_W = 10;
  localparam int OCC_W  = 11;

  localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd0;
  localparam logic [CMD_W-1:0] CMD_EXEC   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FORK   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_MARK   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;

  localparam logic [STAT_W-1:0] STATUS_FOUND    = 3'd0;
  localparam logic [STAT_W-1:0] STATUS_INSERTED = 3'd1;
  localparam logic [STAT_W-1:0] STATUS_NOTFOUND = 3'd2;
  localparam logic [STAT_W-1:0] STATUS_FULL     = 3'd3;
  localparam logic [STAT_W-1:0] STATUS_INVALID  = 3'd4;

  localparam logic [1:0] SLOT_EMPTY = 2'd0;
  localparam logic [1:0] SLOT_OCC   = 2'd1;
  localparam logic [1:0] SLOT_TOMB  = 2'd2;

  typedef enum logic [2:0] {
    RK_REC, RK_CLEAR, RK_NOTFOUND, RK_FULL, RK_INVALID
  } resp_kind_e;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [PID_W-1:0] proc_id;
    logic [PID_W-1:0] child_id;
    logic [PID_W-1:0] parent_id;
    logic [UID_W-1:0] user_id;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic [PID_W-1:0]  rec_pid;
    logic [PID_W-1:0]  rec_ppid;
    logic [UID_W-1:0]  rec_uid;
    logic              exec_flag;
    logic              protected_flag;
    logic              inherited_flag;
    logic              group_code;
    logic [OCC_W-1:0]  occupied;
  } out_item_t;

  typedef struct packed {
    logic [PID_W-1:0] pid;
    logic [PID_W-1:0] ppid;
    logic [UID_W-1:0] uid;
    logic             exec_flag;
    logic             prot;
    logic             inh;
    logic             grp;
  } record_t;

  typedef struct packed {
    logic [1:0] state;
    record_t    rec;
  } entry_t;

  typedef struct packed {
    logic       load;
    logic       clr_init;
    logic       clr_step;
    logic       hash_init;
    logic       key_child;
    logic       hash_step;
    logic       probe_init;
    logic       rd_en;
    logic       advance;
    logic       note_parent;
    logic       found_at;
    logic       place;
    logic       wr_en;
    logic       cnt_clear;
    logic       cnt_inc;
    logic       resp_load;
    resp_kind_e resp_kind;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             invalid;
    logic             clr_last;
    logic             hash_done;
    logic             slot_empty;
    logic             slot_tomb;
    logic             slot_hit;
    logic             probe_last;
    logic             have_tomb;
    logic             cnt_full;
    logic             out_free;
  } dp_stat_t;

endpackage

@@ hw/rtl/ptlp_ram.sv @@
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module ptlp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

@@ hw/rtl/ptlp_datapath.sv @@
// Process table datapath: item register, pid hash, probe pointer, table RAM,
// record merge, occupied count and result register. Uses ptlp_pkg, ptlp_ram.
`include "assert_macros.svh"
module ptlp_datapath #(
  parameter int unsigned TABLE_SLOTS = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ptlp_pkg::in_item_t   in_item_i,
  input  ptlp_pkg::ctrl_cmd_t  cmd_i,
  output ptlp_pkg::dp_stat_t   stat_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ptlp_pkg::out_item_t  out_item_o
);
  import ptlp_pkg::*;

  localparam int unsigned IDX_W      = $clog2(TABLE_SLOTS);
  localparam int unsigned CNT_W      = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned HASH_STEPS = 3;
  localparam int unsigned HCNT_W     = 2;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);
  localparam logic [PID_W-1:0] SLOTS_P  = PID_W'(TABLE_SLOTS);
  // floor(2^PID_W / TABLE_SLOTS): quotient estimate is exact or one low
  localparam logic [PID_W-1:0] RECIP    = PID_W'((64'd1 << PID_W) / 64'(TABLE_SLOTS));

  in_item_t         item_q;
  logic [PID_W-1:0] key_q, key_d;
  logic [HCNT_W-1:0] hcnt_q, hcnt_d;
  logic [IDX_W-1:0] rem_q, rem_d;
  logic [PID_W-1:0] qest_q, qest_d, diff_q, diff_d;
  logic             keysel_q, keysel_d;
  logic [IDX_W-1:0] idx_q, idx_d, n_q, n_d, tomb_q, tomb_d, slot_q, slot_d, ps_q, ps_d;
  logic [IDX_W-1:0] clr_q, clr_d;
  logic             have_tomb_q, have_tomb_d, present_q, present_d;
  logic             pfound_q, pfound_d, pprot_q, pprot_d;
  record_t          rec_q, rec_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  logic [2*PID_W-1:0] prod;
  logic [PID_W-1:0] qmul;
  logic [PID_W-1:0] target;
  entry_t           rd_entry, wr_entry;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, idx_next;
  record_t          new_rec, resp_rec;
  logic             inherit;

  ptlp_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE_SLOTS)) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_entry),
    .re_i    (cmd_i.rd_en),
    .raddr_i (idx_q),
    .rdata_o (rd_entry)
  );

  assign target   = keysel_q ? item_q.child_id : item_q.proc_id;
  assign prod     = key_q * RECIP;
  assign qmul     = qest_q * SLOTS_P;
  assign idx_next = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
  assign inherit  = pfound_q && pprot_q && (ps_q != slot_q);

  always_comb begin
    new_rec = rec_q;
    case (item_q.command)
      CMD_EXEC: begin
        new_rec.pid       = item_q.proc_id;
        new_rec.ppid      = item_q.parent_id;
        new_rec.uid       = item_q.user_id;
        new_rec.exec_flag = 1'b1;
        new_rec.prot      = present_q & rec_q.prot;
        new_rec.inh       = present_q & rec_q.inh;
        new_rec.grp       = present_q & rec_q.grp;
      end
      CMD_FORK: begin
        new_rec.pid       = item_q.child_id;
        new_rec.ppid      = item_q.proc_id;
        new_rec.uid       = item_q.user_id;
        new_rec.exec_flag = 1'b0;
        new_rec.prot      = inherit;
        new_rec.inh       = inherit;
        new_rec.grp       = inherit;
      end
      CMD_MARK: begin
        new_rec.prot = 1'b1;
        new_rec.grp  = 1'b1;
      end
      default: ;
    endcase
    resp_rec = ((item_q.command == CMD_LOOKUP) || (item_q.command == CMD_REMOVE)) ?
               rec_q : new_rec;
  end

  always_comb begin
    ram_we         = cmd_i.clr_step | cmd_i.wr_en;
    ram_waddr      = cmd_i.clr_step ? clr_q : slot_q;
    wr_entry.state = cmd_i.clr_step ? SLOT_EMPTY :
                     (item_q.command == CMD_REMOVE) ? SLOT_TOMB : SLOT_OCC;
    wr_entry.rec   = new_rec;
  end

  always_comb begin
    key_d = key_q; hcnt_d = hcnt_q; rem_d = rem_q; keysel_d = keysel_q;
    qest_d = qest_q; diff_d = diff_q;
    idx_d = idx_q; n_d = n_q; tomb_d = tomb_q; have_tomb_d = have_tomb_q;
    slot_d = slot_q; present_d = present_q; rec_d = rec_q;
    pfound_d = pfound_q; pprot_d = pprot_q; ps_d = ps_q;
    clr_d = clr_q; cnt_d = cnt_q;
    if (cmd_i.hash_init) begin
      key_d    = cmd_i.key_child ? item_q.child_id : item_q.proc_id;
      keysel_d = cmd_i.key_child;
      hcnt_d   = HCNT_W'(HASH_STEPS);
      rem_d    = '0;
    end else if (cmd_i.hash_step) begin
      // three-stage pipe: quotient estimate, remainder estimate, final correction
      hcnt_d = hcnt_q - 1'b1;
      qest_d = prod[2*PID_W-1:PID_W];
      diff_d = key_q - qmul;
      rem_d  = (diff_q >= SLOTS_P) ? IDX_W'(diff_q - SLOTS_P) : IDX_W'(diff_q);
    end
    if (cmd_i.probe_init) begin
      idx_d = rem_q; n_d = '0; have_tomb_d = 1'b0;
    end else if (cmd_i.advance) begin
      idx_d = idx_next;
      n_d   = n_q + 1'b1;
      if ((rd_entry.state == SLOT_TOMB) && !have_tomb_q) begin
        tomb_d = idx_q; have_tomb_d = 1'b1;
      end
    end
    if (cmd_i.found_at) begin
      slot_d = idx_q; present_d = 1'b1; rec_d = rd_entry.rec;
    end else if (cmd_i.place) begin
      slot_d = have_tomb_q ? tomb_q : idx_q; present_d = 1'b0;
    end
    if (cmd_i.note_parent) begin
      pfound_d = stat_o.slot_hit; pprot_d = rd_entry.rec.prot; ps_d = idx_q;
    end
    if (cmd_i.clr_init) begin
      clr_d = '0;
    end else if (cmd_i.clr_step) begin
      clr_d = (clr_q == LAST_IDX) ? '0 : clr_q + 1'b1;
    end
    if (cmd_i.cnt_clear) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + 1'b1;
    end else if (cmd_i.wr_en && (item_q.command == CMD_REMOVE) && (cnt_q != '0)) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_comb begin
    logic [31:0] slot_w, cnt_w;
    slot_w = 32'(slot_q);
    cnt_w  = 32'(cnt_d);
    out_d = '0;
    out_d.occupied = cnt_w[OCC_W-1:0];
    case (cmd_i.resp_kind)
      RK_REC: begin
        out_d.status         = present_q ? STATUS_FOUND : STATUS_INSERTED;
        out_d.slot           = slot_w[SLOT_W-1:0];
        out_d.rec_pid        = resp_rec.pid;
        out_d.rec_ppid       = resp_rec.ppid;
        out_d.rec_uid        = resp_rec.uid;
        out_d.exec_flag      = resp_rec.exec_flag;
        out_d.protected_flag = resp_rec.prot;
        out_d.inherited_flag = resp_rec.inh;
        out_d.group_code     = resp_rec.grp;
      end
      RK_CLEAR:    out_d.status = STATUS_FOUND;
      RK_NOTFOUND: out_d.status = STATUS_NOTFOUND;
      RK_FULL:     out_d.status = STATUS_FULL;
      default:     out_d.status = STATUS_INVALID;
    endcase
    out_valid_d = cmd_i.resp_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      hcnt_q      <= '0;
    end else begin
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      hcnt_q      <= hcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_item_i;
    end
    if (cmd_i.resp_load) begin
      out_q <= out_d;
    end
    key_q <= key_d; rem_q <= rem_d; keysel_q <= keysel_d;
    qest_q <= qest_d; diff_q <= diff_d;
    idx_q <= idx_d; n_q <= n_d; tomb_q <= tomb_d; have_tomb_q <= have_tomb_d;
    slot_q <= slot_d; present_q <= present_d; rec_q <= rec_d;
    pfound_q <= pfound_d; pprot_q <= pprot_d; ps_q <= ps_d;
  end

  always_comb begin
    stat_o.command    = item_q.command;
    stat_o.invalid    = (item_q.proc_id == '0) ||
                        ((item_q.command == CMD_FORK) && (item_q.child_id == '0));
    stat_o.clr_last   = (clr_q == LAST_IDX);
    stat_o.hash_done  = (hcnt_q == '0);
    stat_o.slot_empty = (rd_entry.state == SLOT_EMPTY);
    stat_o.slot_tomb  = (rd_entry.state == SLOT_TOMB);
    stat_o.slot_hit   = (rd_entry.state == SLOT_OCC) && (rd_entry.rec.pid == target);
    stat_o.probe_last = (n_q == LAST_IDX);
    stat_o.have_tomb  = have_tomb_q;
    stat_o.cnt_full   = (cnt_q >= CNT_W'(TABLE_SLOTS));
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `PT_ASSERT(a_no_wr_clash, !(cmd_i.clr_step && cmd_i.wr_en), "sweep and record write collide")
  `PT_ASSERT(a_cnt_range, cnt_q <= CNT_W'(TABLE_SLOTS), "occupied count beyond table size")
  `PT_ASSERT_IMP(a_inc_room, cmd_i.cnt_inc, !stat_o.cnt_full, "insert into full table")
  `PT_ASSERT_IMP(a_resp_room, cmd_i.resp_load, stat_o.out_free, "result register overrun")
endmodule

@@ hw/rtl/ptlp_ctrl.sv @@
// Process table controller: sequences clear sweep, hash, probe, claim, write and result steps.
// Uses ptlp_pkg; drives ptlp_datapath through ctrl_cmd_t.
`include "assert_macros.svh"
module ptlp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ptlp_pkg::dp_stat_t  stat_i,
  output ptlp_pkg::ctrl_cmd_t cmd_o
);
  import ptlp_pkg::*;

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DECODE = 4'd2;
  localparam logic [3:0] S_CLR    = 4'd3;
  localparam logic [3:0] S_HASH   = 4'd4;
  localparam logic [3:0] S_RD     = 4'd5;
  localparam logic [3:0] S_CHK    = 4'd6;
  localparam logic [3:0] S_CLAIM  = 4'd7;
  localparam logic [3:0] S_WR     = 4'd8;
  localparam logic [3:0] S_RESP   = 4'd9;

  logic [3:0] state_q, state_d;
  logic       phase_q, phase_d;
  resp_kind_e kind_q, kind_d;
  logic       upsert;

  assign in_ready_o = (state_q == S_IDLE);
  assign upsert = (stat_i.command == CMD_EXEC) || ((stat_i.command == CMD_FORK) && phase_q);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    phase_d = phase_q;
    kind_d  = kind_q;
    cmd_o.resp_kind = kind_q;
    unique case (state_q)
      S_INIT: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        phase_d = 1'b0;
        if (stat_i.command == CMD_CLEAR) begin
          cmd_o.cnt_clear = 1'b1;
          cmd_o.clr_init  = 1'b1;
          state_d = S_CLR;
        end else if (stat_i.command > CMD_CLEAR) begin
          kind_d = RK_NOTFOUND; state_d = S_RESP;
        end else if (stat_i.invalid) begin
          kind_d = RK_INVALID; state_d = S_RESP;
        end else begin
          cmd_o.hash_init = 1'b1;
          state_d = S_HASH;
        end
      end
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          kind_d = RK_CLEAR; state_d = S_RESP;
        end
      end
      S_HASH: begin
        if (stat_i.hash_done) begin
          cmd_o.probe_init = 1'b1;
          state_d = S_RD;
        end else begin
          cmd_o.hash_step = 1'b1;
        end
      end
      S_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (upsert) begin
          if (stat_i.slot_hit) begin
            cmd_o.found_at = 1'b1; state_d = S_WR;
          end else if (stat_i.slot_empty) begin
            cmd_o.place = 1'b1; state_d = S_CLAIM;
          end else if (stat_i.probe_last) begin
            if (stat_i.have_tomb || stat_i.slot_tomb) begin
              cmd_o.place = 1'b1; state_d = S_CLAIM;
            end else begin
              kind_d = RK_FULL; state_d = S_RESP;
            end
          end else begin
            cmd_o.advance = 1'b1; state_d = S_RD;
          end
        end else if (stat_i.slot_hit || stat_i.slot_empty || stat_i.probe_last) begin
          if (stat_i.command == CMD_FORK) begin
            cmd_o.note_parent = 1'b1;
            cmd_o.hash_init   = 1'b1;
            cmd_o.key_child   = 1'b1;
            phase_d = 1'b1;
            state_d = S_HASH;
          end else if (!stat_i.slot_hit) begin
            kind_d = RK_NOTFOUND; state_d = S_RESP;
          end else begin
            cmd_o.found_at = 1'b1;
            if (stat_i.command == CMD_LOOKUP) begin
              kind_d = RK_REC; state_d = S_RESP;
            end else begin
              state_d = S_WR;
            end
          end
        end else begin
          cmd_o.advance = 1'b1; state_d = S_RD;
        end
      end
      S_CLAIM: begin
        if (stat_i.cnt_full) begin
          kind_d = RK_FULL; state_d = S_RESP;
        end else begin
          cmd_o.cnt_inc = 1'b1; state_d = S_WR;
        end
      end
      S_WR: begin
        cmd_o.wr_en = 1'b1;
        kind_d = RK_REC;
        state_d = S_RESP;
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.resp_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      phase_q <= 1'b0;
      kind_q  <= RK_NOTFOUND;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      kind_q  <= kind_d;
    end
  end

  `PT_ASSERT_IMP(a_chk_after_rd, state_q == S_CHK, $past(cmd_o.rd_en), "check without read")
  `PT_ASSERT_IMP(a_wr_has_slot, cmd_o.wr_en, $past(cmd_o.found_at) || $past(cmd_o.cnt_inc), "write without slot")
  `PT_ASSERT_IMP(a_load_idle, cmd_o.load, in_ready_o && in_valid_i, "item loaded outside accept")
endmodule

@@ hw/rtl/process_table_linear_probe_core.sv @@
// Process table keyed by pid: open addressing, linear probing, tombstones.
// Steps: decode, hash, a read and a check per probed slot, then claim, write and result as
// the command needs; fork hashes and probes twice. Invalid or unknown command: straight to
// the result. Clear: a sweep of every slot, then the result.
// One item at a time: the next item is accepted in the cycle after the result loads. A held result stalls the next one.
// Reset: async active low; then a sweep of every slot empties the table, in_ready_o low.
module process_table_linear_probe_core #(
  parameter int unsigned TABLE_SLOTS = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ptlp_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ptlp_pkg::out_item_t out_item_o
);
  import ptlp_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  ptlp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ptlp_datapath #(.TABLE_SLOTS(TABLE_SLOTS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );
endmodule

@@ sim/process_table_linear_probe_core_test.sv @@
// Testbench for process_table_linear_probe_core: drives pid events through the
// valid/ready input, predicts every result with a local model of the probe table.
// Depends on ptlp_pkg and the core RTL.
`timescale 1ns / 100ps

module process_table_linear_probe_core_test;
  import ptlp_pkg::*;

  localparam int unsigned SLOTS = 1024;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  process_table_linear_probe_core #(.TABLE_SLOTS(SLOTS)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_item_o(out_item_o)
  );

  // local copy of the table
  logic [1:0]  tbl_state [SLOTS];
  record_t     tbl_rec   [SLOTS];
  int unsigned live_count;

  out_item_t   pending_results[$];
  int          errors;
  int          gap_max;
  int          ready_stall;
  logic [PID_W-1:0] pid_pool[$];

  always #10 clk_i = ~clk_i;

  function automatic int unsigned home_slot(logic [PID_W-1:0] pid);
    return pid % SLOTS;
  endfunction

  function automatic logic [PID_W-1:0] chain_pid(int k);
    return PID_W'(7 + k * SLOTS);
  endfunction

  function automatic bit find_pid(logic [PID_W-1:0] pid, output int unsigned at);
    int unsigned i;
    at = 0;
    for (int unsigned n = 0; n < SLOTS; n++) begin
      i = (home_slot(pid) + n) % SLOTS;
      if (tbl_state[i] == SLOT_EMPTY) return 0;
      if (tbl_state[i] == SLOT_OCC && tbl_rec[i].pid == pid) begin
        at = i;
        return 1;
      end
    end
    return 0;
  endfunction

  // upsert: first tombstone is reused, but the chain is walked to rule out a duplicate
  function automatic bit claim_slot(logic [PID_W-1:0] pid, output int unsigned at,
                                    output bit present);
    int unsigned i;
    int unsigned tomb;
    bit have_tomb;
    bit usable;
    have_tomb = 0;
    tomb = 0;
    usable = 0;
    present = 0;
    at = 0;
    for (int unsigned n = 0; n < SLOTS && !usable; n++) begin
      i = (home_slot(pid) + n) % SLOTS;
      if (tbl_state[i] == SLOT_OCC) begin
        if (tbl_rec[i].pid == pid) begin
          at = i;
          present = 1;
          usable = 1;
        end
      end else if (tbl_state[i] == SLOT_TOMB) begin
        if (!have_tomb) begin
          have_tomb = 1;
          tomb = i;
        end
      end else begin
        at = have_tomb ? tomb : i;
        usable = 1;
      end
    end
    if (!usable && have_tomb) begin
      at = tomb;
      usable = 1;
    end
    if (!usable) return 0;
    if (!present) begin
      if (live_count >= SLOTS) return 0;
      tbl_rec[at] = '0;
      tbl_state[at] = SLOT_OCC;
      live_count++;
    end
    return 1;
  endfunction

  function automatic out_item_t table_result(logic [STAT_W-1:0] st, int unsigned at,
                                             record_t r);
    out_item_t o;
    o.status = st;
    o.slot = at[SLOT_W-1:0];
    o.rec_pid = r.pid;
    o.rec_ppid = r.ppid;
    o.rec_uid = r.uid;
    o.exec_flag = r.exec_flag;
    o.protected_flag = r.prot;
    o.inherited_flag = r.inh;
    o.group_code = r.grp;
    o.occupied = live_count[OCC_W-1:0];
    return o;
  endfunction

  function automatic out_item_t apply_event(in_item_t it);
    int unsigned at;
    int unsigned par_at;
    bit present;
    bit par_prot;
    record_t old;
    if (it.command == CMD_CLEAR) begin
      foreach (tbl_state[i]) tbl_state[i] = SLOT_EMPTY;
      live_count = 0;
      return table_result(STATUS_FOUND, 0, '0);
    end
    if (it.command > CMD_CLEAR) return table_result(STATUS_NOTFOUND, 0, '0);
    if (it.proc_id == 0 || (it.command == CMD_FORK && it.child_id == 0))
      return table_result(STATUS_INVALID, 0, '0);
    case (it.command)
      CMD_LOOKUP: begin
        if (!find_pid(it.proc_id, at)) return table_result(STATUS_NOTFOUND, 0, '0);
        return table_result(STATUS_FOUND, at, tbl_rec[at]);
      end
      CMD_EXEC: begin
        if (!claim_slot(it.proc_id, at, present)) return table_result(STATUS_FULL, 0, '0);
        tbl_rec[at].pid = it.proc_id;
        tbl_rec[at].ppid = it.parent_id;
        tbl_rec[at].uid = it.user_id;
        tbl_rec[at].exec_flag = 1'b1;
        return table_result(present ? STATUS_FOUND : STATUS_INSERTED, at, tbl_rec[at]);
      end
      CMD_FORK: begin
        par_prot = find_pid(it.proc_id, par_at) && tbl_rec[par_at].prot;
        if (!claim_slot(it.child_id, at, present)) return table_result(STATUS_FULL, 0, '0);
        tbl_rec[at] = '0;
        tbl_rec[at].pid = it.child_id;
        tbl_rec[at].ppid = it.proc_id;
        tbl_rec[at].uid = it.user_id;
        // a fork onto itself overwrote the parent: nothing to inherit
        if (par_prot && par_at != at) begin
          tbl_rec[at].prot = 1'b1;
          tbl_rec[at].inh = 1'b1;
          tbl_rec[at].grp = 1'b1;
        end
        return table_result(present ? STATUS_FOUND : STATUS_INSERTED, at, tbl_rec[at]);
      end
      CMD_REMOVE: begin
        if (!find_pid(it.proc_id, at)) return table_result(STATUS_NOTFOUND, 0, '0);
        old = tbl_rec[at];
        tbl_rec[at] = '0;
        tbl_state[at] = SLOT_TOMB;
        if (live_count > 0) live_count--;
        return table_result(STATUS_FOUND, at, old);
      end
      default: begin
        if (!find_pid(it.proc_id, at)) return table_result(STATUS_NOTFOUND, 0, '0);
        tbl_rec[at].prot = 1'b1;
        tbl_rec[at].grp = 1'b1;
        return table_result(STATUS_FOUND, at, tbl_rec[at]);
      end
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] ERROR: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(string name, longint unsigned got, longint unsigned want);
    if (got != want) report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  // the step that follows an accepted item either sends the next one or idles the bus
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [PID_W-1:0] pid,
                           logic [PID_W-1:0] child, logic [PID_W-1:0] ppid,
                           logic [UID_W-1:0] uid);
    int gap;
    in_item_t it;
    gap = $urandom_range(0, gap_max);
    it = '{command: cmd, proc_id: pid, child_id: child, parent_id: ppid, user_id: uid};
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(apply_event(it));
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        want = pending_results.pop_front();
        check_field("status", out_item_o.status, want.status);
        check_field("slot", out_item_o.slot, want.slot);
        check_field("rec_pid", out_item_o.rec_pid, want.rec_pid);
        check_field("rec_ppid", out_item_o.rec_ppid, want.rec_ppid);
        check_field("rec_uid", out_item_o.rec_uid, want.rec_uid);
        check_field("exec_flag", out_item_o.exec_flag, want.exec_flag);
        check_field("protected_flag", out_item_o.protected_flag, want.protected_flag);
        check_field("inherited_flag", out_item_o.inherited_flag, want.inherited_flag);
        check_field("group_code", out_item_o.group_code, want.group_code);
        check_field("occupied", out_item_o.occupied, want.occupied);
      end
      ready_stall = $urandom_range(0, gap_max);
    end
    if (ready_stall > 0) begin
      out_ready_i <= 1'b0;
      ready_stall--;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic test_directed();
    send_item(CMD_LOOKUP, 5, 0, 0, 0);
    send_item(CMD_EXEC, 0, 0, 1, 1);
    send_item(CMD_FORK, 5, 0, 0, 1);
    send_item(CMD_FORK, 0, 9, 0, 1);
    send_item(CMD_LOOKUP, 0, 0, 0, 0);
    send_item(CMD_EXEC, 5, 0, 1, 32'h1234);
    send_item(CMD_EXEC, 1029, 0, 5, 32'hFFFF_FFFF);
    send_item(CMD_MARK, 5, 0, 0, 0);
    send_item(CMD_EXEC, 5, 0, 23'h7FFFFF, 32'h0);
    send_item(CMD_FORK, 5, 7, 0, 77);
    send_item(CMD_FORK, 5, 5, 0, 78);
    send_item(CMD_FORK, 999, 2053, 0, 79);
    send_item(CMD_REMOVE, 5, 0, 0, 0);
    send_item(CMD_LOOKUP, 2053, 0, 0, 0);
    send_item(CMD_EXEC, 5, 0, 3, 3);
    send_item(CMD_EXEC, 23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 32'hFFFF_FFFF);
    send_item(CMD_MARK, 4242, 0, 0, 0);
    send_item(CMD_REMOVE, 4242, 0, 0, 0);
    send_item(3'd6, 5, 5, 5, 5);
    send_item(3'd7, 0, 0, 0, 0);
    send_item(CMD_CLEAR, 0, 0, 0, 0);
    send_item(CMD_LOOKUP, 1029, 0, 0, 0);
    wait_idle();
  endtask

  // one long chain on a single home slot, with tombstones inside it
  task automatic test_probe_chain();
    send_item(CMD_CLEAR, 0, 0, 0, 0);
    for (int k = 0; k < 16; k++) send_item(CMD_EXEC, chain_pid(k), 0, 1, $urandom());
    send_item(CMD_REMOVE, chain_pid(3), 0, 0, 0);
    send_item(CMD_REMOVE, chain_pid(8), 0, 0, 0);
    send_item(CMD_LOOKUP, chain_pid(15), 0, 0, 0);
    send_item(CMD_EXEC, chain_pid(20), 0, 2, 20);
    send_item(CMD_EXEC, chain_pid(3), 0, 2, 3);
    send_item(CMD_EXEC, chain_pid(15), 0, 4, 15);
    send_item(CMD_MARK, chain_pid(5), 0, 0, 0);
    send_item(CMD_FORK, chain_pid(5), chain_pid(30), 0, 30);
    send_item(CMD_LOOKUP, chain_pid(30), 0, 0, 0);
    send_item(CMD_FORK, chain_pid(5), chain_pid(5), 0, 31);
    send_item(CMD_REMOVE, chain_pid(20), 0, 0, 0);
    send_item(CMD_LOOKUP, chain_pid(20), 0, 0, 0);
    send_item(CMD_LOOKUP, chain_pid(40), 0, 0, 0);
    send_item(CMD_CLEAR, 0, 0, 0, 0);
    wait_idle();
  endtask

  task automatic test_random_events();
    logic [PID_W-1:0] pid;
    logic [PID_W-1:0] child;
    logic [CMD_W-1:0] cmd;
    int pick;
    // clustered homes give long chains with tombstones inside them
    for (int k = 0; k < 40; k++)
      pid_pool.push_back(PID_W'(($urandom_range(0, 7) * 37 + 3) + k * SLOTS));
    for (int k = 0; k < 12; k++) pid_pool.push_back(PID_W'($urandom_range(1, 23'h7FFFFF)));
    for (int n = 0; n < 560; n++) begin
      if (n % 100 == 0) gap_max = (n % 200 == 0) ? 8 : 0;
      pick = $urandom_range(0, 99);
      if (pick < 20) cmd = CMD_LOOKUP;
      else if (pick < 45) cmd = CMD_EXEC;
      else if (pick < 65) cmd = CMD_FORK;
      else if (pick < 80) cmd = CMD_REMOVE;
      else if (pick < 90) cmd = CMD_MARK;
      else if (pick < 91) cmd = CMD_CLEAR;
      else cmd = CMD_W'($urandom_range(0, 7));
      pid = ($urandom_range(0, 19) == 0) ? PID_W'($urandom()) : pid_pool[$urandom_range(0, 51)];
      child = ($urandom_range(0, 19) == 0) ? PID_W'($urandom()) :
              pid_pool[$urandom_range(0, 51)];
      if ($urandom_range(0, 39) == 0) pid = 0;
      if ($urandom_range(0, 39) == 0) child = 0;
      send_item(cmd, pid, child, PID_W'($urandom()), $urandom());
    end
    gap_max = 8;
    wait_idle();
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    out_ready_i = 1'b0;
    errors = 0;
    gap_max = 8;
    ready_stall = 0;
    live_count = 0;
    foreach (tbl_state[i]) begin
      tbl_state[i] = SLOT_EMPTY;
      tbl_rec[i] = '0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_probe_chain();
    test_random_events();
    repeat (50) @(posedge clk_i);
    if (pending_results.size() != 0) report_mismatch("results still outstanding at end");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/ptlp_pkg.sv
hw/rtl/ptlp_ram.sv
hw/rtl/ptlp_datapath.sv
hw/rtl/ptlp_ctrl.sv
hw/rtl/process_table_linear_probe_core.sv
sim/process_table_linear_probe_core_test.sv
